FILE: rtl/szed_pkg.sv
// Shared constants, types and codes for the stick zone event detector.
package szed_pkg;

    localparam int ZONES      = 4;
    localparam int COORD_BITS = 12;

    localparam int ZIDX_W     = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CNT_W      = 3;
    localparam int ACT_W      = ((ZIDX_W + 1) > CNT_W) ? (ZIDX_W + 1) : CNT_W;
    localparam int WORD_W     = 2 * COORD_BITS + 2;
    localparam int CFG_IDX_W  = $clog2(2 + ZONES);
    localparam int CFG_DATA_W = WORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ZONE0      = CFG_IDX_W'(2);

    typedef logic [1:0] t_zstate;

    localparam t_zstate ZS_IDLE   = 2'd0;
    localparam t_zstate ZS_ENTER  = 2'd1;
    localparam t_zstate ZS_INSIDE = 2'd2;
    localparam t_zstate ZS_LEAVE  = 2'd3;

    typedef struct packed {
        logic              load_sample;
        logic              scan_en;
        logic [ZIDX_W-1:0] zone_idx;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_stop;
        logic scan_last;
        logic active_zero;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/szed_sample_if.sv
// Valid/ready channel that carries one stick sample per beat.
interface szed_sample_if;
    logic                            valid;
    logic                            ready;
    logic [szed_pkg::COORD_BITS-1:0] stick_x;
    logic [szed_pkg::COORD_BITS-1:0] stick_y;

    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink (input valid, input stick_x, input stick_y, output ready);
endinterface

FILE: rtl/szed_result_if.sv
// Valid/ready channel that carries one zone event result per beat.
interface szed_result_if;
    logic                         valid;
    logic                         ready;
    logic [szed_pkg::ZONES-1:0]   fired_mask;
    logic [2*szed_pkg::ZONES-1:0] zone_states;

    modport source (output valid, output fired_mask, output zone_states, input ready);
    modport sink (input valid, input fired_mask, input zone_states, output ready);
endinterface

FILE: rtl/stick_zone_event_detector_core.sv
// Top level of the stick zone event detector.
// Use: write the dead band, zone count and zone words through the
// configuration port while the block is idle, then send stick samples on
// i_sample and take one result beat per sample on o_result.
// Each result carries the mask of fired zones and all stored zone states.
// Timing: after a sample beat is accepted the zones are scanned one per
// cycle from zone zero, and the scan ends at the first zone that changes to
// entering, inside or leaving, or after the last active zone.
// If no zone is active, no zone is scanned. A new sample is accepted only
// in idle, after the last result has been loaded into the output register.
// After the scan the controller waits in its done state until the output
// register is free; it then loads the result and returns to idle.
// The result sits in an output register, so a new sample can be taken and
// scanned while a result waits; if the receiver stalls, the next scan holds
// its result until the register is free.
// Reset clears the configuration and control registers, returns every zone
// to idle and leaves no result pending; sample and result data are not reset.
module stick_zone_event_detector_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [szed_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [szed_pkg::CFG_DATA_W-1:0] i_cfg_data,
    szed_sample_if.sink                     i_sample,
    szed_result_if.source                   o_result
);
    import szed_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_sample.ready = in_ready;

    szed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    szed_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_stick_x     (i_sample.stick_x),
        .i_stick_y     (i_sample.stick_y),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_fired_mask  (o_result.fired_mask),
        .o_zone_states (o_result.zone_states)
    );

endmodule

FILE: rtl/szed_ctrl.sv
// Controller state machine that sequences the zone scan, one zone per cycle.
module szed_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  szed_pkg::t_status i_status,
    output szed_pkg::t_cmd    o_cmd
);
    import szed_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ZIDX_W-1:0] r_idx;
    logic [ZIDX_W-1:0] n_idx;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_cmd            = '0;
        o_cmd.zone_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_sample = 1'b1;
                    n_idx             = '0;
                    n_state           = i_status.active_zero ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_status.scan_stop || i_status.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN || r_state == S_DONE))
        else $error("accepted beat did not start a scan");

    a_stop_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_status.scan_stop) |=> (r_state == S_DONE))
        else $error("scan went on after a zone stopped it");

endmodule

FILE: rtl/szed_dp.sv
// Datapath: configuration registers, zone states, window compare and result register.
module szed_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [szed_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [szed_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [szed_pkg::COORD_BITS-1:0] i_stick_x,
    input  logic [szed_pkg::COORD_BITS-1:0] i_stick_y,
    input  szed_pkg::t_cmd                  i_cmd,
    output szed_pkg::t_status               o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [szed_pkg::ZONES-1:0]      o_fired_mask,
    output logic [2*szed_pkg::ZONES-1:0]    o_zone_states
);
    import szed_pkg::*;

    logic [COORD_BITS-1:0] r_dead_band;
    logic [CNT_W-1:0]      r_zone_count;
    logic [WORD_W-1:0]     r_zone_word [ZONES];
    t_zstate               r_zstate [ZONES];
    logic [COORD_BITS-1:0] r_sx;
    logic [COORD_BITS-1:0] r_sy;
    logic                  r_out_valid;
    logic [ZONES-1:0]      r_fired;
    logic [2*ZONES-1:0]    r_states;

    logic [ACT_W-1:0]      active;
    logic [ACT_W-1:0]      idx_p1;
    logic [WORD_W-1:0]     cur_word;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic                  in_x;
    logic                  in_y;
    logic                  in_win;
    t_zstate               cur_s;
    t_zstate               nxt_s;
    logic                  stop;
    logic [ZONES-1:0]      fired;
    logic [2*ZONES-1:0]    states;

    assign active = (int'(r_zone_count) > ZONES) ? ACT_W'(ZONES) : ACT_W'(r_zone_count);
    assign idx_p1 = ACT_W'(i_cmd.zone_idx) + ACT_W'(1);

    assign cur_word = r_zone_word[i_cmd.zone_idx];
    assign tx       = cur_word[COORD_BITS-1:0];
    assign ty       = cur_word[2*COORD_BITS-1:COORD_BITS];
    assign cur_s    = r_zstate[i_cmd.zone_idx];

    assign in_x = ({1'b0, r_sx} <= ({1'b0, tx} + {1'b0, r_dead_band}))
               && (({1'b0, r_sx} + {1'b0, r_dead_band}) >= {1'b0, tx});
    assign in_y = ({1'b0, r_sy} <= ({1'b0, ty} + {1'b0, r_dead_band}))
               && (({1'b0, r_sy} + {1'b0, r_dead_band}) >= {1'b0, ty});
    assign in_win = in_x && in_y;

    always_comb begin
        nxt_s = cur_s;
        stop  = 1'b0;
        unique case (cur_s)
            ZS_IDLE: begin
                if (in_win) begin
                    nxt_s = ZS_ENTER;
                    stop  = 1'b1;
                end
            end
            ZS_ENTER: begin
                if (in_win) begin
                    nxt_s = ZS_INSIDE;
                    stop  = 1'b1;
                end
            end
            ZS_INSIDE: begin
                if (!in_win) begin
                    nxt_s = ZS_LEAVE;
                    stop  = 1'b1;
                end
            end
            ZS_LEAVE: begin
                nxt_s = ZS_IDLE;
            end
            default: begin
                nxt_s = cur_s;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < ZONES; i++) begin
            fired[i] = (ACT_W'(i) < active) && (r_zstate[i] != ZS_IDLE)
                    && (r_zstate[i] == r_zone_word[i][WORD_W-1:2*COORD_BITS]);
            states[2*i +: 2] = r_zstate[i];
        end
    end

    assign o_status.scan_stop   = stop;
    assign o_status.scan_last   = (idx_p1 == active);
    assign o_status.active_zero = (active == '0);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band  <= '0;
            r_zone_count <= '0;
            for (int i = 0; i < ZONES; i++) begin
                r_zone_word[i] <= '0;
                r_zstate[i]    <= ZS_IDLE;
            end
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DEAD_BAND) begin
                    r_dead_band <= i_cfg_data[COORD_BITS-1:0];
                end else if (i_cfg_idx == REG_ZONE_COUNT) begin
                    r_zone_count <= i_cfg_data[CNT_W-1:0];
                end else begin
                    for (int i = 0; i < ZONES; i++) begin
                        if (i_cfg_idx == (REG_ZONE0 + CFG_IDX_W'(i))) begin
                            r_zone_word[i] <= i_cfg_data[WORD_W-1:0];
                        end
                    end
                end
            end
            if (i_cmd.scan_en) begin
                r_zstate[i_cmd.zone_idx] <= nxt_s;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sx <= i_stick_x;
            r_sy <= i_stick_y;
        end
        if (i_cmd.load_out) begin
            r_fired  <= fired;
            r_states <= states;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fired_mask  = r_fired;
    assign o_zone_states = r_states;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_en |-> (ACT_W'(i_cmd.zone_idx) < active))
        else $error("scan reached a zone beyond the active count");

    a_stop_leaves_nonidle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_en && stop) |=> (r_zstate[$past(i_cmd.zone_idx)] != ZS_IDLE))
        else $error("stopping zone was left idle");

endmodule

FILE: dv/stick_zone_event_detector_core_test.sv
// Self-checking testbench for the stick zone event detector core.
module stick_zone_event_detector_core_test;
    import szed_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 120;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_ZONE0 + CFG_IDX_W'(ZONES);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = REG_UNUSED_LO + CFG_IDX_W'(1);

    typedef struct packed {
        logic [ZONES-1:0]   fired_mask;
        logic [2*ZONES-1:0] zone_states;
    } t_zone_report;

    class zone_event_model;
        logic [COORD_BITS-1:0] dead_band;
        logic [CNT_W-1:0]      zone_count;
        logic [WORD_W-1:0]     zone_word [ZONES];
        t_zstate               zone_state [ZONES];
        t_zone_report          due_reports [$];
        int                    mismatches;

        function new();
            dead_band  = '0;
            zone_count = '0;
            mismatches = 0;
            for (int i = 0; i < ZONES; i++) begin
                zone_word[i]  = '0;
                zone_state[i] = ZS_IDLE;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DEAD_BAND) begin
                dead_band = data[COORD_BITS-1:0];
            end else if (idx == REG_ZONE_COUNT) begin
                zone_count = data[CNT_W-1:0];
            end else if (idx >= REG_ZONE0 && idx < REG_ZONE0 + CFG_IDX_W'(ZONES)) begin
                zone_word[idx - REG_ZONE0] = data[WORD_W-1:0];
            end
        endfunction

        function bit near(int pos, int target);
            return (pos <= target + int'(dead_band)) && (pos + int'(dead_band) >= target);
        endfunction

        function int due_count();
            return due_reports.size();
        endfunction

        // Advance the zone states for one accepted sample beat and queue its report.
        function void take_sample(logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy);
            int           active;
            bit           hit;
            bit           stopped;
            t_zstate      s;
            t_zone_report rep;
            active  = (int'(zone_count) > ZONES) ? ZONES : int'(zone_count);
            stopped = 1'b0;
            rep     = '0;
            for (int i = 0; i < active; i++) begin
                if (!stopped) begin
                    hit = near(int'(sx), int'(zone_word[i][COORD_BITS-1:0])) &&
                          near(int'(sy), int'(zone_word[i][2*COORD_BITS-1:COORD_BITS]));
                    s = zone_state[i];
                    if (hit && s == ZS_IDLE) begin
                        zone_state[i] = ZS_ENTER;
                        stopped = 1'b1;
                    end else if (hit && s == ZS_ENTER) begin
                        zone_state[i] = ZS_INSIDE;
                        stopped = 1'b1;
                    end else if (!hit && s == ZS_INSIDE) begin
                        zone_state[i] = ZS_LEAVE;
                        stopped = 1'b1;
                    end else if (s == ZS_LEAVE) begin
                        zone_state[i] = ZS_IDLE;
                    end
                end
            end
            for (int i = 0; i < active; i++) begin
                if (zone_state[i] != ZS_IDLE && zone_state[i] == zone_word[i][WORD_W-1 -: 2])
                    rep.fired_mask[i] = 1'b1;
            end
            for (int i = 0; i < ZONES; i++)
                rep.zone_states[2*i +: 2] = zone_state[i];
            due_reports.push_back(rep);
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        task check_result(logic [ZONES-1:0] fired, logic [2*ZONES-1:0] states);
            t_zone_report rep;
            if (due_reports.size() == 0) begin
                report($sformatf("unexpected result beat fired=%h states=%h", fired, states));
            end else begin
                rep = due_reports.pop_front();
                if (fired !== rep.fired_mask)
                    report($sformatf("fired_mask got %h want %h", fired, rep.fired_mask));
                if (states !== rep.zone_states)
                    report($sformatf("zone_states got %h want %h", states, rep.zone_states));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    szed_sample_if sample_ch ();
    szed_result_if result_ch ();

    zone_event_model       model;
    bit                    hold_request = 1'b0;
    logic [COORD_BITS-1:0] queue_x [$];
    logic [COORD_BITS-1:0] queue_y [$];
    int                    cfg_band;
    int                    cfg_count;
    logic [WORD_W-1:0]     cfg_words [ZONES];

    stick_zone_event_detector_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] zone_word_of(int x, int y, int trig);
        return {trig[1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    function automatic logic [COORD_BITS-1:0] near_coord(int target);
        int reach;
        int off;
        int v;
        reach = cfg_band + 2;
        case ($urandom_range(0, 3))
            0: off = cfg_band;
            1: off = cfg_band + 1;
            default: off = $urandom_range(0, reach);
        endcase
        v = $urandom_range(0, 1) ? target + off : target - off;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic int edge_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? COORD_MAX : 0;
        return $urandom_range(0, COORD_MAX);
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        model.write_reg(idx, data);
    endtask

    task automatic program_zones();
        cfg_write(REG_DEAD_BAND, CFG_DATA_W'(cfg_band));
        cfg_write(REG_ZONE_COUNT, CFG_DATA_W'(cfg_count));
        for (int i = 0; i < ZONES; i++)
            cfg_write(REG_ZONE0 + CFG_IDX_W'(i), cfg_words[i]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_sample(int x, int y);
        queue_x.push_back(x[COORD_BITS-1:0]);
        queue_y.push_back(y[COORD_BITS-1:0]);
    endtask

    task automatic offer_sample(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
        sample_ch.valid   <= 1'b1;
        sample_ch.stick_x <= x;
        sample_ch.stick_y <= y;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        model.take_sample(x, y);
    endtask

    // Send the queued samples in bursts, then wait until every result beat is in.
    task automatic play_queue();
        int burst;
        int gap;
        while (queue_x.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && queue_x.size() > 0) begin
                offer_sample(queue_x.pop_front(), queue_y.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sample_ch.valid <= 1'b0;
        while (model.due_count() != 0) @(posedge clk);
        repeat (ZONES + 4) @(posedge clk);
    endtask

    initial begin
        int stretch;
        int style;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                stretch = $urandom_range(1, 40);
                style   = $urandom_range(0, 3);
                for (int n = 0; n < stretch && !hold_request; n++) begin
                    case (style)
                        0: result_ch.ready <= 1'b1;
                        1: result_ch.ready <= $urandom_range(0, 1);
                        2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: result_ch.ready <= ((n % 8) < 5);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready)
            model.check_result(result_ch.fired_mask, result_ch.zone_states);
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            // Any beat on either channel counts as progress.
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int z;
        int prev;
        model = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= '0;
        cfg_data          <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.stick_x <= '0;
        sample_ch.stick_y <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_band     = 5;
        cfg_count    = 2;
        cfg_words[0] = zone_word_of(100, 100, ZS_INSIDE);
        cfg_words[1] = zone_word_of(0, COORD_MAX, ZS_ENTER);
        cfg_words[2] = zone_word_of(COORD_MAX, 0, ZS_LEAVE);
        cfg_words[3] = zone_word_of(0, 0, ZS_IDLE);
        program_zones();
        queue_sample(100, 100);
        queue_sample(100, 100);
        queue_sample(105, 95);
        queue_sample(106, 100);
        queue_sample(0, COORD_MAX);
        queue_sample(0, COORD_MAX);
        queue_sample(COORD_MAX, COORD_MAX);
        queue_sample(0, 0);
        queue_sample(95, 105);
        queue_sample(94, 100);
        play_queue();

        cfg_band     = COORD_MAX;
        cfg_count    = 7;
        cfg_words[0] = {WORD_W{1'b1}};
        cfg_words[1] = zone_word_of(0, 0, ZS_IDLE);
        cfg_words[2] = zone_word_of(2048, 2048, ZS_ENTER);
        cfg_words[3] = zone_word_of(0, COORD_MAX, ZS_INSIDE);
        cfg_write(REG_UNUSED_LO, {CFG_DATA_W{1'b1}});
        cfg_write(REG_UNUSED_HI, {CFG_DATA_W{1'b1}});
        program_zones();
        queue_sample(0, 0);
        queue_sample(COORD_MAX, COORD_MAX);
        queue_sample(0, COORD_MAX);
        queue_sample(COORD_MAX, 0);
        queue_sample(2048, 2048);
        queue_sample(2048, 2048);
        queue_sample(1, 1);
        queue_sample(COORD_MAX, 1);
        play_queue();

        cfg_band  = 0;
        cfg_count = 0;
        program_zones();
        queue_sample(0, 0);
        queue_sample(COORD_MAX, COORD_MAX);
        play_queue();
        cfg_count    = ZONES;
        cfg_words[0] = zone_word_of(COORD_MAX, 0, ZS_ENTER);
        program_zones();
        queue_sample(COORD_MAX, 0);
        queue_sample(COORD_MAX - 1, 0);
        play_queue();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0: cfg_band = 0;
                1: cfg_band = COORD_MAX;
                default: cfg_band = $urandom_range(0, 60);
            endcase
            cfg_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : ZONES;
            for (int i = 0; i < ZONES; i++) begin
                if (i > 0 && $urandom_range(0, 3) == 0) begin
                    prev = $urandom_range(0, i - 1);
                    cfg_words[i] = {2'($urandom_range(0, 3)), cfg_words[prev][2*COORD_BITS-1:0]};
                end else begin
                    cfg_words[i] = zone_word_of(edge_coord(), edge_coord(),
                                                $urandom_range(0, 3));
                end
            end
            program_zones();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    queue_sample($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                end else begin
                    z = $urandom_range(0, ZONES - 1);
                    queue_sample(near_coord(int'(cfg_words[z][COORD_BITS-1:0])),
                                 near_coord(int'(cfg_words[z][2*COORD_BITS-1:COORD_BITS])));
                end
            end
            if (phase == 3)
                hold_request = 1'b1;
            play_queue();
        end

        if (model.due_count() != 0)
            model.report("expected result beat never arrived");
        if (model.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: stick_zone_event_detector_core.f
rtl/szed_pkg.sv
rtl/szed_sample_if.sv
rtl/szed_result_if.sv
rtl/szed_ctrl.sv
rtl/szed_dp.sv
rtl/stick_zone_event_detector_core.sv
dv/stick_zone_event_detector_core_test.sv
